[sv/hse_pkg.sv]
// ----------------------------------------------------------------------------
// hse_pkg
// Types and constants shared by the hash set engine modules.
// ----------------------------------------------------------------------------
package hse_pkg;

  localparam int KEY_W       = 32;
  localparam int HASH_W      = 24;          // hash < 10000010
  localparam int RED_W       = 29;          // (h + d) * 31 + 7 < 2^29
  localparam int STEP_W      = 5;
  localparam int HRED_STEPS  = 5;           // reduction by M << 4 .. M << 0

  localparam logic [RED_W-1:0] HASH_MOD = RED_W'(10000010);
  localparam logic [RED_W-1:0] HASH_MUL = RED_W'(31);
  localparam logic [RED_W-1:0] HASH_ADD = RED_W'(7);
  localparam logic [KEY_W-1:0] RADIX    = KEY_W'(10);

  // n / 10 == (n * 0xCCCCCCCD) >> 35 for every 32-bit n
  localparam logic [KEY_W-1:0] DIV10_MUL = 32'hCCCC_CCCD;
  localparam int               DIV10_SH  = 35;
  localparam int               QUOT_W    = 29;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_FIND   = 2'd1,
    OP_DELETE = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_FOLD,
    S_HRED,
    S_READ,
    S_UPD
  } state_t;

  typedef struct packed {
    logic    found;
    status_t status;
    logic    val_we;
    logic    vld_we;
  } hse_upd_t;

endpackage

[sv/hse_ram.sv]
// ----------------------------------------------------------------------------
// hse_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/hse_csub.sv]
// ----------------------------------------------------------------------------
// hse_csub
// Shared compare-subtract step used for every modular reduction.
// ----------------------------------------------------------------------------
module hse_csub
  import hse_pkg::*;
(
  input  logic [RED_W-1:0] rem_in,
  input  logic [RED_W-1:0] dvs,
  output logic [RED_W-1:0] rem_out
);

  assign rem_out = (rem_in >= dvs) ? (rem_in - dvs) : rem_in;

endmodule

[sv/hse_match.sv]
// ----------------------------------------------------------------------------
// hse_match
// Bucket row lookup: finds the first matching and first free slot and
// builds the row to write back for the operation.
// ----------------------------------------------------------------------------
module hse_match
  import hse_pkg::*;
#(
  parameter int WAYS = 4
) (
  input  logic [KEY_W-1:0]      key_value,
  input  logic [1:0]            opcode,
  input  logic [WAYS*KEY_W-1:0] row_val,
  input  logic [WAYS-1:0]       row_vld,
  output logic [WAYS*KEY_W-1:0] new_val,
  output logic [WAYS-1:0]       new_vld,
  output hse_upd_t              upd
);

  logic [WAYS-1:0] hit;
  logic [WAYS-1:0] first_hit;
  logic [WAYS-1:0] first_free;
  logic            any_hit;
  logic            any_free;

  always_comb begin
    any_hit    = 1'b0;
    any_free   = 1'b0;
    first_hit  = '0;
    first_free = '0;
    for (int w = 0; w < WAYS; w++) begin
      hit[w] = row_vld[w] && (row_val[w*KEY_W +: KEY_W] == key_value);
      if (hit[w] && !any_hit) begin
        first_hit[w] = 1'b1;
        any_hit      = 1'b1;
      end
      if (!row_vld[w] && !any_free) begin
        first_free[w] = 1'b1;
        any_free      = 1'b1;
      end
    end
  end

  always_comb begin
    new_val    = row_val;
    new_vld    = row_vld;
    upd.found  = any_hit;
    upd.status = ST_OK;
    upd.val_we = 1'b0;
    upd.vld_we = 1'b0;
    case (opcode)
      OP_INSERT: begin
        if (any_free) begin
          upd.val_we = 1'b1;
          upd.vld_we = 1'b1;
          new_vld    = row_vld | first_free;
          for (int w = 0; w < WAYS; w++) begin
            if (first_free[w]) begin
              new_val[w*KEY_W +: KEY_W] = key_value;
            end
          end
        end else begin
          upd.status = ST_FULL;
        end
      end
      OP_DELETE: begin
        if (any_hit) begin
          upd.vld_we = 1'b1;
          new_vld    = row_vld & ~first_hit;
        end else begin
          upd.status = ST_ABSENT;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[sv/hash_set_engine_unit.sv]
// ----------------------------------------------------------------------------
// hash_set_engine_unit
// Hash set of 32-bit integers: insert, find and delete on bucketed slots.
// ----------------------------------------------------------------------------
// Input word (s_*): opcode (0 insert, 1 find, 2 delete; 3 acts as find) and
// a signed 32-bit key. Output word (m_*): found and status (0 ok, 1 bucket
// full on insert, 2 absent on delete). One output word per input word.
// The key hash folds decimal digits with a shared compare-subtract unit:
// each digit takes one multiply for /10, one fold and five reduction
// steps. The low clog2(BUCKETS) hash bits pick the bucket (BUCKETS is a
// power of two), followed by a row read and a write-back. Zero and
// negative keys skip the digit loop. One word is in work at a time:
// s_tready is high only when idle, so a new word is taken only once the
// previous one has finished its update.
// After reset the valid RAM is swept to zero, one bucket per cycle, before
// s_tready rises. A stalled output holds its word; a new input word may be
// taken meanwhile, and its update waits until the previous output word has
// been taken.
// ----------------------------------------------------------------------------
module hash_set_engine_unit
  import hse_pkg::*;
#(
  parameter int BUCKETS = 4096,
  parameter int WAYS    = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [1:0] opcode, [33:2] key_value, rest zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // [0] found, [2:1] status, rest zero
);

  localparam int BW = $clog2(BUCKETS);

  state_t state, state_next;

  logic [1:0]        op;
  logic [KEY_W-1:0]  key;
  logic [KEY_W-1:0]  n;
  logic [QUOT_W-1:0] quot;
  logic [HASH_W-1:0] h;
  logic [RED_W-1:0]  r;
  logic [STEP_W-1:0] step;
  logic [BW-1:0]     clr_idx;
  logic              found_q;
  status_t           status_q;

  logic [2*KEY_W-1:0] prod;
  logic [KEY_W-1:0]   q10;
  logic [3:0]         digit;
  logic [RED_W-1:0]   fold_x;
  logic [RED_W-1:0]   dvs;
  logic [RED_W-1:0]   csub_out;
  logic               upd_go;
  logic               key_skip;

  logic                  val_we, vld_we;
  logic [BW-1:0]         vld_waddr;
  logic [WAYS-1:0]       vld_wdata;
  logic [WAYS*KEY_W-1:0] row_val, new_val;
  logic [WAYS-1:0]       row_vld, new_vld;
  hse_upd_t              upd;

  assign key_skip = s_tdata[33] || (s_tdata[33:2] == '0);
  assign upd_go   = (state == S_UPD) && (!m_tvalid || m_tready);

  assign prod   = n * DIV10_MUL;
  assign q10    = KEY_W'(quot) * RADIX;
  assign digit  = 4'(n - q10);
  assign fold_x = (RED_W'(h) + RED_W'(digit)) * HASH_MUL + HASH_ADD;

  hse_csub u_csub (
    .rem_in  (r),
    .dvs     (dvs),
    .rem_out (csub_out)
  );

  hse_ram #(.WIDTH(WAYS*KEY_W), .DEPTH(BUCKETS)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (r[BW-1:0]),
    .wdata (new_val),
    .raddr (r[BW-1:0]),
    .rdata (row_val)
  );

  hse_ram #(.WIDTH(WAYS), .DEPTH(BUCKETS)) u_vld_ram (
    .clk   (clk),
    .we    (vld_we),
    .waddr (vld_waddr),
    .wdata (vld_wdata),
    .raddr (r[BW-1:0]),
    .rdata (row_vld)
  );

  hse_match #(.WAYS(WAYS)) u_match (
    .key_value (key),
    .opcode    (op),
    .row_val   (row_val),
    .row_vld   (row_vld),
    .new_val   (new_val),
    .new_vld   (new_vld),
    .upd       (upd)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_idx == BW'(BUCKETS - 1)) state_next = S_IDLE;
      S_IDLE:  if (s_tvalid) state_next = key_skip ? S_READ : S_DIV;
      S_DIV:   state_next = S_FOLD;
      S_FOLD:  state_next = S_HRED;
      S_HRED:  if (step == '0) state_next = (n == '0) ? S_READ : S_DIV;
      S_READ:  state_next = S_UPD;
      S_UPD:   if (upd_go) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = (state == S_IDLE);
    dvs       = HASH_MOD << step;
    val_we    = upd_go && upd.val_we;
    vld_we    = (state == S_CLEAR) || (upd_go && upd.vld_we);
    vld_waddr = (state == S_CLEAR) ? clr_idx : r[BW-1:0];
    vld_wdata = (state == S_CLEAR) ? '0 : new_vld;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_idx  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (upd_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op  <= s_tdata[1:0];
        key <= s_tdata[33:2];
        n   <= s_tdata[33:2];
        h   <= '0;
        r   <= '0;
      end
      S_DIV: begin
        quot <= prod[DIV10_SH +: QUOT_W];
      end
      S_FOLD: begin
        n    <= KEY_W'(quot);
        r    <= fold_x;
        step <= STEP_W'(HRED_STEPS - 1);
      end
      S_HRED: begin
        r <= csub_out;
        if (step == '0) begin
          h <= csub_out[HASH_W-1:0];
        end else begin
          step <= step - 1'b1;
        end
      end
      S_UPD: begin
        if (upd_go) begin
          found_q  <= upd.found;
          status_q <= upd.status;
        end
      end
      default: begin
      end
    endcase
  end

  assign m_tdata = {5'b0, status_q, found_q};

  a_absent_not_found: assert property (@(posedge clk) disable iff (rst)
    upd_go && (upd.status == ST_ABSENT) |-> !upd.found)
    else $error("absent status with found set");

  a_read_hash_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (r < HASH_MOD))
    else $error("bucket hash not reduced");

  a_hash_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (RED_W'(h) < HASH_MOD))
    else $error("hash not reduced");

  a_no_write_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !val_we && !s_tready)
    else $error("activity during clear pass");

  a_result_once: assert property (@(posedge clk) disable iff (rst)
    upd_go |=> (state == S_IDLE) && m_tvalid)
    else $error("result not presented after update");

endmodule
